/* src/itrl_pkg.sv */
// ----------------------------------------------------------------------------
// itrl_pkg
// Shared types and constants for the interlocked timed relay lines block.
// ----------------------------------------------------------------------------
package itrl_pkg;

  localparam int unsigned MAX_LINES_DEF = 8;
  localparam int unsigned TIME_W        = 48;
  localparam int unsigned DEADLINE_W    = 49;
  localparam int unsigned DUR_W         = 16;
  localparam int unsigned PROD_W        = 26;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 64;

  localparam logic [9:0]  MS_PER_SECOND = 10'd1000;
  localparam logic [63:0] DEFAULT_WORD  = 64'h0258_0258_0258_0258;

  typedef enum logic [1:0] {
    REQ_CMD     = 2'd0,
    REQ_TICK    = 2'd1,
    REQ_ALL_OFF = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_DISABLED = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTERLOCK = 3'd0,
    REG_LINES     = 3'd1,
    REG_ENABLE    = 3'd2,
    REG_DUR_LOW   = 3'd3,
    REG_DUR_HIGH  = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CMD,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic         interlock_enable;
    logic [3:0]   lines_in_use;
    logic [7:0]   line_enable_mask;
    logic [127:0] default_durations;
  } cfg_t;

endpackage

/* src/itrl_if.sv */
// ----------------------------------------------------------------------------
// itrl_if
// Valid/ready channels for requests, results and configuration writes.
// ----------------------------------------------------------------------------
interface itrl_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [2:0]  line_index;
  logic        turn_on;
  logic [15:0] duration_seconds;
  logic [47:0] time_ms;

  modport source (output valid, req_type, line_index, turn_on, duration_seconds, time_ms,
                  input ready);
  modport sink   (input valid, req_type, line_index, turn_on, duration_seconds, time_ms,
                  output ready);
endinterface

interface itrl_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] relay_mask;
  logic [7:0] switched_off_mask;

  modport source (output valid, status, relay_mask, switched_off_mask, input ready);
  modport sink   (input valid, status, relay_mask, switched_off_mask, output ready);
endinterface

interface itrl_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/itrl_cfg_regs.sv */
// ----------------------------------------------------------------------------
// itrl_cfg_regs
// Configuration register file; any write to a listed register clears the lines.
// ----------------------------------------------------------------------------
module itrl_cfg_regs
  import itrl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  itrl_cfg_if.sink   cfg_i,
  input  logic       busy_i,
  output cfg_t       cfg_o,
  output logic       clear_o
);

  cfg_t cfg_q, cfg_d;
  logic wr;

  assign cfg_i.ready = !busy_i;
  assign wr          = cfg_i.valid && cfg_i.ready;

  always_comb begin
    cfg_d   = cfg_q;
    clear_o = 1'b0;
    if (wr) begin
      unique case (cfg_i.index)
        REG_INTERLOCK: begin
          cfg_d.interlock_enable = cfg_i.data[0];
          clear_o = 1'b1;
        end
        REG_LINES: begin
          cfg_d.lines_in_use = cfg_i.data[3:0];
          clear_o = 1'b1;
        end
        REG_ENABLE: begin
          cfg_d.line_enable_mask = cfg_i.data[7:0];
          clear_o = 1'b1;
        end
        REG_DUR_LOW: begin
          cfg_d.default_durations[63:0] = cfg_i.data;
          clear_o = 1'b1;
        end
        REG_DUR_HIGH: begin
          cfg_d.default_durations[127:64] = cfg_i.data;
          clear_o = 1'b1;
        end
        default: begin
          // writes beyond the register list are dropped
          clear_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interlock_enable  <= 1'b1;
      cfg_q.lines_in_use      <= 4'd8;
      cfg_q.line_enable_mask  <= 8'hFF;
      cfg_q.default_durations <= {DEFAULT_WORD, DEFAULT_WORD};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/interlocked_timed_relay_lines.sv */
// ----------------------------------------------------------------------------
// interlocked_timed_relay_lines
// Relay line controller with per-line millisecond deadlines and interlock.
// ----------------------------------------------------------------------------
// Requests enter on req_i (line command, tick, all-off) and each one gives
// exactly one result on rsp_o: a status, the relay on mask after the request
// and the mask of lines switched off by it. cfg_i writes the five registers
// while the block is idle; a write to a listed register clears all lines.
// Deadlines live in a single-port-write memory with a registered read port.
// Switch-on command: the request is registered, EXEC multiplies the duration
// by 1000, CMD adds it to the time and writes it back, DONE loads the result.
// Tick: after EXEC, SCAN reads the deadline memory one line per cycle, DRAIN
// takes the last read data and DONE loads the result; each expired line is
// written back zero as its read data returns. Switch-off, all-off, rejected
// commands and ticks with no lines in use go from EXEC straight to DONE. One
// request is in flight at a time; the next is accepted once the previous
// result is in the output register, even if the receiver has not taken it.
// If the receiver stalls with a result still pending, a finished request
// waits in its final state. Reset switches every line off and restores the
// register defaults; the deadline memory needs no clearing as off lines are ignored.
// ----------------------------------------------------------------------------
module interlocked_timed_relay_lines
  import itrl_pkg::*;
#(
  parameter int unsigned MAX_LINES = MAX_LINES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  itrl_req_if.sink    req_i,
  itrl_rsp_if.source  rsp_o,
  itrl_cfg_if.sink    cfg_i
);

  localparam int unsigned LINE_AW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

  state_e state_q, state_d;

  cfg_t cfg;
  logic cfg_clear;

  logic [1:0]        req_type_q;
  logic [2:0]        idx_q;
  logic              on_q;
  logic [DUR_W-1:0]  dur_q;
  logic [TIME_W-1:0] now_q;

  logic [MAX_LINES-1:0] line_on_q, line_on_d;
  logic [MAX_LINES-1:0] off_q, off_d;
  logic [MAX_LINES-1:0] count_mask;
  logic [1:0]           status_q, status_d;
  logic [PROD_W-1:0]    prod_q, prod_d;
  logic [LINE_AW-1:0]   scan_q, scan_d;
  logic [LINE_AW-1:0]   rd_idx_q, rd_idx_d;
  logic                 rd_v_q, rd_v_d;

  logic [DEADLINE_W-1:0] dl_mem [MAX_LINES];
  logic [DEADLINE_W-1:0] rd_data_q;
  logic                  mem_we;
  logic [LINE_AW-1:0]    mem_waddr, mem_raddr;
  logic [DEADLINE_W-1:0] mem_wdata;

  logic        out_valid_q;
  logic [1:0]  out_status_q;
  logic [7:0]  out_relay_q;
  logic [7:0]  out_off_q;
  logic        out_load;

  logic [3:0]       count;
  logic             accept;
  logic             last_scan;
  logic             tick_hit;
  logic [DUR_W-1:0] dur_sel;
  logic [LINE_AW-1:0] idx_a;

  itrl_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .busy_i  (state_q != S_IDLE),
    .cfg_o   (cfg),
    .clear_o (cfg_clear)
  );

  assign count = (cfg.lines_in_use > 4'(MAX_LINES)) ? 4'(MAX_LINES) : cfg.lines_in_use;

  always_comb begin
    for (int i = 0; i < MAX_LINES; i++) begin
      count_mask[i] = (4'(i) < count);
    end
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign idx_a       = idx_q[LINE_AW-1:0];
  assign last_scan   = ((4'(scan_q) + 4'd1) == count);
  assign dur_sel     = (dur_q == '0) ? cfg.default_durations[{idx_q, 4'b0000} +: DUR_W]
                                     : dur_q;
  assign tick_hit    = rd_v_q && line_on_q[rd_idx_q] && (rd_data_q != '0) &&
                       ({1'b0, now_q} >= rd_data_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        priority if (req_type_q == REQ_CMD) begin
          if (({1'b0, idx_q} < count) && cfg.line_enable_mask[idx_q] && on_q) begin
            state_d = S_CMD;
          end else begin
            state_d = S_DONE;
          end
        end else if (req_type_q == REQ_TICK) begin
          state_d = (count == 4'd0) ? S_DONE : S_SCAN;
        end else begin
          state_d = S_DONE;
        end
      end
      S_CMD:   state_d = S_DONE;
      S_SCAN:  state_d = last_scan ? S_DRAIN : S_SCAN;
      S_DRAIN: state_d = S_DONE;
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    line_on_d = line_on_q;
    off_d     = off_q;
    status_d  = status_q;
    prod_d    = prod_q;
    scan_d    = scan_q;
    rd_idx_d  = rd_idx_q;
    rd_v_d    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = idx_a;
    mem_wdata = '0;
    mem_raddr = scan_q;
    out_load  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          off_d    = '0;
          status_d = ST_OK;
          scan_d   = '0;
        end
      end
      S_EXEC: begin
        prod_d = PROD_W'(dur_sel) * PROD_W'(MS_PER_SECOND);
        if (req_type_q == REQ_CMD) begin
          priority if ({1'b0, idx_q} >= count) begin
            status_d = ST_RANGE;
          end else if (!cfg.line_enable_mask[idx_q]) begin
            status_d = ST_DISABLED;
          end else if (!on_q) begin
            off_d[idx_a]     = line_on_q[idx_a];
            line_on_d[idx_a] = 1'b0;
            mem_we           = 1'b1;
          end else begin
            status_d = ST_OK;
          end
        end else if (req_type_q == REQ_ALL_OFF) begin
          off_d     = line_on_q;
          line_on_d = '0;
        end
      end
      S_CMD: begin
        if (cfg.interlock_enable) begin
          for (int i = 0; i < MAX_LINES; i++) begin
            if (LINE_AW'(i) != idx_a && count_mask[i] && line_on_q[i]) begin
              off_d[i]     = 1'b1;
              line_on_d[i] = 1'b0;
            end
          end
        end
        line_on_d[idx_a] = 1'b1;
        mem_we           = 1'b1;
        mem_wdata        = {1'b0, now_q} + DEADLINE_W'(prod_q);
      end
      S_SCAN: begin
        rd_v_d   = 1'b1;
        rd_idx_d = scan_q;
        scan_d   = scan_q + LINE_AW'(1);
      end
      S_DRAIN: begin
      end
      S_DONE: begin
        out_load = !out_valid_q || rsp_o.ready;
      end
      default: begin
      end
    endcase

    // compare returning deadline, write back zero for an expired line
    if (tick_hit) begin
      off_d[rd_idx_q]     = 1'b1;
      line_on_d[rd_idx_q] = 1'b0;
      mem_we              = 1'b1;
      mem_waddr           = rd_idx_q;
      mem_wdata           = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      line_on_q   <= '0;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      line_on_q <= cfg_clear ? '0 : line_on_d;
      rd_v_q    <= rd_v_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_type_q <= req_i.req_type;
      idx_q      <= req_i.line_index;
      on_q       <= req_i.turn_on;
      dur_q      <= req_i.duration_seconds;
      now_q      <= req_i.time_ms;
    end
    off_q    <= off_d;
    status_q <= status_d;
    prod_q   <= prod_d;
    scan_q   <= scan_d;
    rd_idx_q <= rd_idx_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_relay_q  <= 8'(line_on_q);
      out_off_q    <= 8'(off_q);
    end
  end

  // deadline memory
  always_ff @(posedge clk_i) begin
    if (mem_we) dl_mem[mem_waddr] <= mem_wdata;
    rd_data_q <= dl_mem[mem_raddr];
  end

  assign rsp_o.valid             = out_valid_q;
  assign rsp_o.status            = out_status_q;
  assign rsp_o.relay_mask        = out_relay_q;
  assign rsp_o.switched_off_mask = out_off_q;

`ifndef SYNTHESIS
  a_no_line_beyond_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (line_on_q & ~count_mask) == '0)
    else $error("line on at index beyond line count");

  a_interlock_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg.interlock_enable |-> ($countones(line_on_q) <= 1))
    else $error("more than one line on with interlock set");

  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_v_q |-> (state_q == S_SCAN || state_q == S_DRAIN))
    else $error("deadline read returned outside a tick scan");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result appeared outside the final state");

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_clear |=> line_on_q == '0)
    else $error("configuration write did not clear the lines");
`endif

endmodule
